[src/mgba_pkg.sv]
// ----------------------------------------------------------------------------
// mgba_pkg
// shared widths, codes and word types of the multi-gain bridge averager
// ----------------------------------------------------------------------------
package mgba_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COUNT_WIDTH  = 16;
	localparam int SLOT_COUNT   = 3;
	localparam int TOTAL_WIDTH  = 16;

	// accumulator holds up to 2**COUNT_WIDTH samples without overflow
	localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
	// conversion counter reaches the latched sample count
	localparam int CNT_WIDTH    = COUNT_WIDTH + 1;
	// divider runs one sign-fix step plus one step per dividend bit
	localparam int DIV_STEPS    = SUM_WIDTH + 1;
	localparam int DIV_STEP_W   = $clog2(DIV_STEPS + 1);

	localparam int CFG_DATA_W   = COUNT_WIDTH;
	localparam int CFG_INDEX_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK    = 1'b1;

	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_SAMPLE   = 2'd1;
	localparam logic [1:0] OP_SHUTDOWN = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PARAM = 2'd1,
		ST_BAD_STATE = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		GAIN_NONE = 2'd0,
		GAIN_A128 = 2'd1,
		GAIN_B32  = 2'd2,
		GAIN_A64  = 2'd3
	} gain_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_DIVIDE = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]                     operation;
		logic signed [SAMPLE_WIDTH-1:0] sample_value;
		logic [2:0]                     request_source;
	} in_word_t;

	typedef struct packed {
		logic [1:0]                     status;
		logic                           done_res;
		logic signed [SAMPLE_WIDTH-1:0] average_slot0;
		logic signed [SAMPLE_WIDTH-1:0] average_slot1;
		logic signed [SAMPLE_WIDTH-1:0] average_slot2;
		logic [2:0]                     channels_measured;
		logic [2:0]                     source_out;
		logic [TOTAL_WIDTH-1:0]         measurement_total;
		logic [1:0]                     gain_select;
		logic                           busy_res;
	} out_word_t;

endpackage

[src/mgba_divider.sv]
// ----------------------------------------------------------------------------
// mgba_divider
// serial restoring divider: signed sum over unsigned count, one bit a cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
module mgba_divider (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [mgba_pkg::SUM_WIDTH-1:0]   dividend,
	input  logic [mgba_pkg::COUNT_WIDTH-1:0]        divisor,
	output logic                                    done,
	output logic signed [mgba_pkg::SAMPLE_WIDTH-1:0] quotient
);
	import mgba_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic                     neg_q;
	logic [DIV_STEP_W-1:0]    step_q;
	logic [SUM_WIDTH-1:0]     acc_q;
	logic [COUNT_WIDTH-1:0]   rem_q;
	logic [COUNT_WIDTH-1:0]   div_q;

	logic [COUNT_WIDTH:0]     trial;
	logic [COUNT_WIDTH+1:0]   diff;
	logic                     q_bit;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, acc_q[SUM_WIDTH-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign q_bit = ~diff[COUNT_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			neg_q <= dividend[SUM_WIDTH-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (step_q == DIV_STEP_W'(DIV_STEPS)) begin
				// magnitude first
				if (neg_q) begin
					acc_q <= -acc_q;
				end
			end else begin
				acc_q <= {acc_q[SUM_WIDTH-2:0], q_bit};
				rem_q <= q_bit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -acc_q[SAMPLE_WIDTH-1:0] : acc_q[SAMPLE_WIDTH-1:0];

endmodule

[src/multi_gain_bridge_averager.sv]
// ----------------------------------------------------------------------------
// multi_gain_bridge_averager
// per-channel averaging of bridge converter samples over up to three gains
// ----------------------------------------------------------------------------
// A start word latches the sample count and channel mask, clears the stored
// averages and selects the first gain (A128, then B32, then A64). Each sample
// word then feeds the running sum: the first sample of a channel is dropped,
// the next N are summed, and the sum divided by N (truncated toward zero) goes
// to the next free slot in measurement order. Every accepted word returns
// exactly one result word showing the state after it. Start, shutdown,
// ignored and summed samples load the result register directly; the
// sample that closes a channel runs the serial divider, one quotient bit per
// cycle over the 40-bit sum plus a sign step, and its result is loaded when
// the divider is done, no word being taken while it runs. Words are taken
// only while the output register is empty or draining in the same cycle.
module multi_gain_bridge_averager (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  mgba_pkg::in_word_t                    in_data,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output mgba_pkg::out_word_t                   out_data,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [mgba_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mgba_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mgba_pkg::*;

	// gain code to its bit in the channel masks
	function automatic logic [2:0] gain_bit(gain_t g);
		logic [2:0] b;
		unique case (g)
			GAIN_A128: b = 3'b001;
			GAIN_B32:  b = 3'b010;
			GAIN_A64:  b = 3'b100;
			default:   b = 3'b000;
		endcase
		return b;
	endfunction

	// priority pick of the next channel still pending
	function automatic gain_t pick_gain(logic [2:0] p);
		gain_t g;
		if (p[0]) begin
			g = GAIN_A128;
		end else if (p[1]) begin
			g = GAIN_B32;
		end else if (p[2]) begin
			g = GAIN_A64;
		end else begin
			g = GAIN_NONE;
		end
		return g;
	endfunction

	// configuration registers
	logic [COUNT_WIDTH-1:0]          cfg_count_q;
	logic [2:0]                      cfg_mask_q;

	// measurement state
	state_t                          state_q, state_d;
	logic                            phase_q, phase_d;
	logic [2:0]                      pending_q, pending_d;
	gain_t                           gain_q, gain_d;
	logic [CNT_WIDTH-1:0]            cnt_q, cnt_d;
	logic signed [SUM_WIDTH-1:0]     sum_q, sum_d;
	logic signed [SAMPLE_WIDTH-1:0]  slot_q [SLOT_COUNT];
	logic signed [SAMPLE_WIDTH-1:0]  slot_d [SLOT_COUNT];
	logic [2:0]                      measured_q, measured_d;
	logic [2:0]                      source_q, source_d;
	logic [TOTAL_WIDTH-1:0]          total_q, total_d;
	logic [COUNT_WIDTH-1:0]          held_cnt_q, held_cnt_d;

	// output register
	logic                            out_valid_q;
	out_word_t                       out_data_q;

	// step control
	logic                            accept;
	logic                            load_out;
	logic                            done_flag;
	status_t                         status;
	logic                            div_start;
	logic                            div_done;
	logic signed [SAMPLE_WIDTH-1:0]  div_quot;
	logic signed [SUM_WIDTH-1:0]     sum_next;
	logic [1:0]                      slot_idx;
	gain_t                           next_gain;

	// words are taken in idle when the result register is free by the edge
	assign in_stall = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept   = in_valid && !in_stall;

	// sample added to the running sum, sign extended
	assign sum_next = sum_q + {{COUNT_WIDTH{in_data.sample_value[SAMPLE_WIDTH-1]}},
		in_data.sample_value};

	// next free slot is the number of channels already stored
	assign slot_idx = 2'(measured_q[0]) + 2'(measured_q[1]) + 2'(measured_q[2]);
	assign next_gain = pick_gain(pending_q);

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		pending_d  = pending_q;
		gain_d     = gain_q;
		cnt_d      = cnt_q;
		sum_d      = sum_q;
		slot_d     = slot_q;
		measured_d = measured_q;
		source_d   = source_q;
		total_d    = total_q;
		held_cnt_d = held_cnt_q;
		load_out   = 1'b0;
		done_flag  = 1'b0;
		status     = ST_OK;
		div_start  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					unique case (in_data.operation)
						OP_START: begin
							// parameter check ahead of the state check
							if (cfg_count_q == '0 || cfg_mask_q == '0) begin
								status = ST_BAD_PARAM;
							end else if (phase_q) begin
								status = ST_BAD_STATE;
							end else begin
								for (int i = 0; i < SLOT_COUNT; i++) begin
									slot_d[i] = '0;
								end
								measured_d = '0;
								held_cnt_d = cfg_count_q;
								cnt_d      = '0;
								sum_d      = '0;
								gain_d     = pick_gain(cfg_mask_q);
								pending_d  = cfg_mask_q & ~gain_bit(pick_gain(cfg_mask_q));
								source_d   = in_data.request_source;
								phase_d    = 1'b1;
							end
						end
						OP_SAMPLE: begin
							if (!phase_q) begin
								status = ST_IGNORED;
							end else if (cnt_q == '0) begin
								// settling sample after a gain change is dropped
								cnt_d = CNT_WIDTH'(1);
								sum_d = '0;
							end else if (cnt_q < {1'b0, held_cnt_q}) begin
								cnt_d = cnt_q + 1'b1;
								sum_d = sum_next;
							end else begin
								// last sample of the channel: hand the sum to the divider
								load_out  = 1'b0;
								sum_d     = sum_next;
								div_start = 1'b1;
								state_d   = S_DIVIDE;
							end
						end
						OP_SHUTDOWN: begin
							if (!phase_q) begin
								status = ST_BAD_STATE;
							end else begin
								phase_d = 1'b0;
								gain_d  = GAIN_NONE;
							end
						end
						default: begin
							status = ST_BAD_PARAM;
						end
					endcase
				end
			end
			S_DIVIDE: begin
				if (div_done) begin
					if (slot_idx < 2'(SLOT_COUNT) && gain_q != GAIN_NONE) begin
						slot_d[slot_idx] = div_quot;
						measured_d       = measured_q | gain_bit(gain_q);
					end
					gain_d    = next_gain;
					pending_d = pending_q & ~gain_bit(next_gain);
					cnt_d     = '0;
					sum_d     = '0;
					if (next_gain == GAIN_NONE) begin
						total_d   = total_q + 1'b1;
						phase_d   = 1'b0;
						done_flag = 1'b1;
					end
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	mgba_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (held_cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= COUNT_WIDTH'(1);
			cfg_mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLES: cfg_count_q <= cfg_data;
				REG_MASK:    cfg_mask_q  <= cfg_data[2:0];
				default:     cfg_mask_q  <= cfg_mask_q;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= 1'b0;
			pending_q  <= '0;
			gain_q     <= GAIN_NONE;
			cnt_q      <= '0;
			sum_q      <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
			measured_q <= '0;
			source_q   <= '0;
			total_q    <= '0;
			held_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			gain_q     <= gain_d;
			cnt_q      <= cnt_d;
			sum_q      <= sum_d;
			slot_q     <= slot_d;
			measured_q <= measured_d;
			source_q   <= source_d;
			total_q    <= total_d;
			held_cnt_q <= held_cnt_d;
		end
	end

	// result register, shows the state after the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.status            <= status;
			out_data_q.done_res          <= done_flag;
			out_data_q.average_slot0     <= slot_d[0];
			out_data_q.average_slot1     <= slot_d[1];
			out_data_q.average_slot2     <= slot_d[2];
			out_data_q.channels_measured <= measured_d;
			out_data_q.source_out        <= source_d;
			out_data_q.measurement_total <= total_d;
			out_data_q.gain_select       <= gain_d;
			out_data_q.busy_res          <= phase_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a running measurement always has a gain selected
	a_gain_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> gain_q != GAIN_NONE)
		else $error("measurement running with no gain selected");

	// conversion counter never passes the latched count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= {1'b0, held_cnt_q})
		else $error("conversion counter beyond sample count");

	// divider completes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVIDE)
		else $error("divider finished outside the divide state");

	// a new result never lands on one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || !out_stall)
		else $error("result register overwritten while stalled");

endmodule
